// ===== hw/rtl/sts_pkg.sv =====
package sts_pkg;

    localparam int MaxGenes      = 16;
    localparam int MaxTsize      = 8;
    localparam int GeneW         = 18;
    localparam int IdxW          = 8;
    localparam int FitW          = 23;
    localparam int CfgIdxW       = 2;
    localparam int CfgDataW      = 5;

    localparam logic [CfgIdxW-1:0] CfgNumGenes = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgTsize    = 2'd1;

    localparam logic [4:0] NumGenesReset = 5'd10;
    localparam logic [3:0] TsizeReset    = 4'd2;

    localparam logic [32:0] PiQ30      = 33'd3373259426;
    localparam logic [32:0] HalfPiQ30  = 33'd1686629713;
    localparam logic [35:0] TwoPiQ30   = 36'd6746518852;
    localparam logic [30:0] OneQ30     = 31'd1073741824;
    localparam logic [16:0] OffsetQ8   = 17'd107259;
    localparam logic signed [24:0] FitMax = 25'sd4194303;
    localparam logic signed [24:0] FitMin = -25'sd4194304;

    function automatic logic [6:0] horner_div(input logic [2:0] k);
        logic [6:0] d;
        case (k)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor), at most one short of the true quotient
    function automatic logic [31:0] horner_recip(input logic [2:0] k);
        logic [31:0] m;
        case (k)
            3'd0:    m = 32'd39045157;
            3'd1:    m = 32'd59652323;
            3'd2:    m = 32'd102261126;
            3'd3:    m = 32'd214748364;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

    function automatic logic signed [FitW-1:0] sat23(input logic signed [24:0] v);
        logic signed [FitW-1:0] r;
        if (v > FitMax) begin
            r = FitMax[FitW-1:0];
        end else if (v < FitMin) begin
            r = FitMin[FitW-1:0];
        end else begin
            r = v[FitW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/sts_if.sv =====
interface sts_gene_if import sts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [GeneW-1:0] gene_value;
    logic [IdxW-1:0]         candidate_index;
    modport source (output valid, gene_value, candidate_index, input ready);
    modport sink (input valid, gene_value, candidate_index, output ready);
endinterface

interface sts_winner_if import sts_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [IdxW-1:0]        winner_index;
    logic signed [FitW-1:0] winner_fitness;
    modport source (output valid, winner_index, winner_fitness, input ready);
    modport sink (input valid, winner_index, winner_fitness, output ready);
endinterface

interface sts_cfg_if import sts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/schwefel_tournament_select.sv =====
// channel   dir  payload                           handshake
// i_gene    in   gene_value, candidate_index       valid/ready
// o_winner  out  winner_index, winner_fitness      valid/ready
// i_cfg     in   index, data                       valid/ready, ready while idle
// one item runs through 19 square root steps, the reduction steps and five sine
// series rounds (multiply, reciprocal multiply, correction), plus a fitness step when it
// ends a candidate; the sine rounds and the products around them share one multiplier
// ready only while the sequencer is idle; a configuration write goes before an item
// a result sits in the output register; a stalled result holds back the next tournament end
// reset is synchronous, active low, and loads the register defaults
module schwefel_tournament_select import sts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sts_gene_if.sink    i_gene,
    sts_winner_if.source o_winner,
    sts_cfg_if.sink     i_cfg
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_SQRT = 15'b000000000000010,
        S_MOD  = 15'b000000000000100,
        S_FOLD = 15'b000000000001000,
        S_T2W  = 15'b000000000010000,
        S_T2   = 15'b000000000100000,
        S_HMW  = 15'b000000001000000,
        S_HLD  = 15'b000000010000000,
        S_HRW  = 15'b000000100000000,
        S_HDIV = 15'b000001000000000,
        S_SW   = 15'b000010000000000,
        S_S    = 15'b000100000000000,
        S_TW   = 15'b001000000000000,
        S_TERM = 15'b010000000000000,
        S_FIT  = 15'b100000000000000
    } t_state;

    t_state r_state;
    logic [4:0]  r_num_genes;
    logic [3:0]  r_tsize;
    logic [3:0]  r_gcnt;
    logic [2:0]  r_ccnt;
    logic signed [FitW-1:0] r_psum;
    logic [IdxW-1:0] r_cur;
    logic signed [FitW-1:0] r_best_fit;
    logic [IdxW-1:0] r_best_idx;
    logic        r_out_valid;
    logic [IdxW-1:0] r_win_idx;
    logic signed [FitW-1:0] r_win_fit;

    logic        r_xneg;
    logic        r_sneg;
    logic [17:0] r_a;
    logic [37:0] r_n;
    logic [20:0] r_rem;
    logic [18:0] r_root;
    logic [35:0] r_x;
    logic [30:0] r_t;
    logic [31:0] r_t2;
    logic [31:0] r_dvd;
    logic [4:0]  r_cnt;
    logic [2:0]  r_hcnt;
    logic [31:0] r_op_a;
    logic [31:0] r_op_b;
    logic [63:0] r_prod;

    logic [4:0] ng;
    logic [3:0] ts;
    logic [20:0] sq_rem;
    logic [20:0] sq_trial;
    logic [35:0] mod_sub;
    logic [32:0] fold1;
    logic        fold_neg;
    logic [32:0] fold2;
    logic [6:0]  dv_div;
    logic [31:0] hq_est;
    logic [31:0] hq_back;
    logic [31:0] hq_rem;
    logic [31:0] hq;
    logic [30:0] hp;
    logic [31:0] s_val;
    logic [15:0] sv;
    logic [18:0] mag;
    logic signed [24:0] sum_w;
    logic [21:0] off;
    logic signed [FitW-1:0] fit;
    logic        cand_last;
    logic        tour_last;
    logic        fit_go;
    logic        take;

    assign ng = (r_num_genes == 5'd0) ? 5'd1 : (r_num_genes > 5'd16) ? 5'd16 : r_num_genes;
    assign ts = (r_tsize == 4'd0) ? 4'd1 : (r_tsize > 4'd8) ? 4'd8 : r_tsize;

    assign sq_rem   = {r_rem[18:0], r_n[37:36]};
    assign sq_trial = {r_root, 2'b01};
    assign mod_sub  = TwoPiQ30 << (2'd2 - r_cnt[1:0]);
    assign fold_neg = (r_x[32:0] >= PiQ30);
    assign fold1    = fold_neg ? (r_x[32:0] - PiQ30) : r_x[32:0];
    assign fold2    = (fold1 > HalfPiQ30) ? (PiQ30 - fold1) : fold1;
    assign dv_div   = horner_div(r_hcnt);
    assign hq_est   = r_prod[63:32];
    assign hq_back  = hq_est * {25'b0, dv_div};
    assign hq_rem   = r_dvd - hq_back;
    assign hq       = (hq_rem >= {25'b0, dv_div}) ? (hq_est + 32'd1) : hq_est;
    assign hp       = OneQ30 - hq[30:0];
    assign s_val    = r_prod[61:30];
    assign sv       = 16'((s_val + 32'd32768) >> 16);
    assign mag      = 19'((r_prod + 64'd8192) >> 14);
    assign sum_w    = (r_xneg != r_sneg)
                      ? (25'(r_psum) - $signed({6'b0, mag}))
                      : (25'(r_psum) + $signed({6'b0, mag}));
    assign off      = OffsetQ8 * ng;
    assign fit      = sat23($signed({3'b0, off}) - 25'(r_psum));
    assign cand_last = ({1'b0, r_gcnt} + 5'd1) >= ng;
    assign tour_last = ({1'b0, r_ccnt} + 4'd1) >= ts;
    assign fit_go    = (r_state == S_FIT) && (!tour_last || !r_out_valid || o_winner.ready);
    assign take      = (r_ccnt == 3'd0) || (fit < r_best_fit);

    assign i_gene.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready  = (r_state == S_IDLE);
    assign o_winner.valid          = r_out_valid;
    assign o_winner.winner_index   = r_win_idx;
    assign o_winner.winner_fitness = r_win_fit;

    always_ff @(posedge i_clk) begin
        r_prod <= r_op_a * r_op_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_genes <= NumGenesReset;
            r_tsize     <= TsizeReset;
            r_gcnt      <= '0;
            r_ccnt      <= '0;
            r_psum      <= '0;
            r_cur       <= '0;
            r_best_fit  <= '0;
            r_best_idx  <= '0;
            r_out_valid <= 1'b0;
            r_win_idx   <= '0;
            r_win_fit   <= '0;
        end else begin
            if (fit_go && tour_last) begin
                r_out_valid <= 1'b1;
            end else if (o_winner.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg.valid) begin
                        if (i_cfg.index == CfgNumGenes || i_cfg.index == CfgTsize) begin
                            if (i_cfg.index == CfgNumGenes) begin
                                r_num_genes <= i_cfg.data;
                            end else begin
                                r_tsize <= i_cfg.data[3:0];
                            end
                            r_gcnt <= '0;
                            r_ccnt <= '0;
                            r_psum <= '0;
                        end
                    end else if (i_gene.valid) begin
                        r_xneg <= i_gene.gene_value[17];
                        r_a    <= i_gene.gene_value[17] ? 18'(-i_gene.gene_value)
                                                        : i_gene.gene_value;
                        r_n    <= {(i_gene.gene_value[17] ? 18'(-i_gene.gene_value)
                                                          : i_gene.gene_value), 20'b0};
                        r_rem  <= '0;
                        r_root <= '0;
                        r_cnt  <= '0;
                        if (r_gcnt == 4'd0) begin
                            r_cur  <= i_gene.candidate_index;
                            r_psum <= '0;
                        end
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_n <= {r_n[35:0], 2'b00};
                    if (sq_rem >= sq_trial) begin
                        r_rem  <= sq_rem - sq_trial;
                        r_root <= {r_root[17:0], 1'b1};
                    end else begin
                        r_rem  <= sq_rem;
                        r_root <= {r_root[17:0], 1'b0};
                    end
                    if (r_cnt == 5'd18) begin
                        r_cnt   <= '0;
                        r_state <= S_MOD;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_MOD: begin
                    if (r_cnt == 5'd0) begin
                        r_x <= {1'b0, r_root, 16'b0};
                        r_cnt <= 5'd1;
                    end else begin
                        if (r_x >= mod_sub) begin
                            r_x <= r_x - mod_sub;
                        end
                        if (r_cnt == 5'd3) begin
                            r_state <= S_FOLD;
                        end
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_FOLD: begin
                    r_sneg  <= fold_neg;
                    r_t     <= fold2[30:0];
                    r_op_a  <= {1'b0, fold2[30:0]};
                    r_op_b  <= {1'b0, fold2[30:0]};
                    r_state <= S_T2W;
                end
                S_T2W: begin
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_t2    <= r_prod[61:30];
                    r_op_a  <= r_prod[61:30];
                    r_op_b  <= {1'b0, OneQ30};
                    r_hcnt  <= '0;
                    r_state <= S_HMW;
                end
                S_HMW: begin
                    r_state <= S_HLD;
                end
                S_HLD: begin
                    r_dvd   <= r_prod[61:30];
                    r_op_a  <= r_prod[61:30];
                    r_op_b  <= horner_recip(r_hcnt);
                    r_state <= S_HRW;
                end
                S_HRW: begin
                    r_state <= S_HDIV;
                end
                S_HDIV: begin
                    r_op_b <= {1'b0, hp};
                    if (r_hcnt == 3'd4) begin
                        r_op_a  <= {1'b0, r_t};
                        r_state <= S_SW;
                    end else begin
                        r_op_a  <= r_t2;
                        r_hcnt  <= r_hcnt + 3'd1;
                        r_state <= S_HMW;
                    end
                end
                S_SW: begin
                    r_state <= S_S;
                end
                S_S: begin
                    r_op_a  <= {14'b0, r_a};
                    r_op_b  <= {16'b0, sv};
                    r_state <= S_TW;
                end
                S_TW: begin
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    r_psum <= sat23(sum_w);
                    if (cand_last) begin
                        r_gcnt  <= '0;
                        r_state <= S_FIT;
                    end else begin
                        r_gcnt  <= r_gcnt + 4'd1;
                        r_state <= S_IDLE;
                    end
                end
                S_FIT: begin
                    if (fit_go) begin
                        r_psum <= '0;
                        if (take) begin
                            r_best_fit <= fit;
                            r_best_idx <= r_cur;
                        end
                        if (tour_last) begin
                            r_ccnt    <= '0;
                            r_win_idx <= take ? r_cur : r_best_idx;
                            r_win_fit <= take ? fit : r_best_fit;
                        end else begin
                            r_ccnt <= r_ccnt + 3'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_out_from_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIT))
        else $error("result raised outside fitness step");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_gene.valid && i_gene.ready) |=> (r_state == S_SQRT))
        else $error("accepted item did not start square root");

    a_ccnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_ccnt} < ts) || $past(i_cfg.valid))
        else $error("candidate count beyond tournament size");

endmodule

// ===== bench/sts_tb_if.sv =====
`timescale 1ns / 100ps
package sts_tb_types;
    import sts_pkg::*;
    typedef struct packed {
        logic [IdxW-1:0]         idx;
        logic signed [FitW-1:0]  fit;
    } t_winner;
endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import sts_pkg::*;
    import sts_tb_types::*;

    class winner_board;
        t_winner pending[$];
        int      errors;
        int unsigned ng, ts, gcnt, ccnt, cur_idx, best_idx;
        longint  psum, best_fit;

        function new();
            errors = 0;
            ng = 10; ts = 2;
            gcnt = 0; ccnt = 0; psum = 0; cur_idx = 0; best_fit = 0; best_idx = 0;
        endfunction

        function longint clip23(longint v);
            if (v > 4194303) return 4194303;
            if (v < -4194304) return -4194304;
            return v;
        endfunction

        function longint unsigned root64(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint gene_term(logic [GeneW-1:0] raw);
            longint unsigned a, t, t2, p, s, sv, mag, r, one;
            longint unsigned dv[5];
            bit xneg, sneg;
            dv = '{110, 72, 42, 20, 6};
            one = 64'd1 << 30;
            xneg = raw[GeneW-1];
            a = xneg ? (64'h40000 - raw) : raw;
            r = root64(a << 20);
            t = (r << 16) % (2 * 64'd3373259426);
            sneg = 0;
            if (t >= 64'd3373259426) begin
                t -= 64'd3373259426;
                sneg = 1;
            end
            if (t > 64'd1686629713) t = 64'd3373259426 - t;
            t2 = (t * t) >> 30;
            p = one;
            for (int i = 0; i < 5; i++) p = one - (((t2 * p) >> 30) / dv[i]);
            s = (t * p) >> 30;
            sv = (s + 32768) >> 16;
            mag = (a * sv + 8192) >> 14;
            return (xneg != sneg) ? -longint'(mag) : longint'(mag);
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
            if (idx == CfgNumGenes) ng = d;
            else if (idx == CfgTsize) ts = d[3:0];
            else return;
            gcnt = 0; ccnt = 0; psum = 0;
        endfunction

        function void note_gene(logic [GeneW-1:0] g, logic [IdxW-1:0] ci);
            int unsigned eg, et;
            longint fit;
            eg = (ng < 1) ? 1 : (ng > MaxGenes ? MaxGenes : ng);
            et = (ts < 1) ? 1 : (ts > 8 ? 8 : ts);
            if (gcnt == 0) begin
                cur_idx = ci;
                psum = 0;
            end
            psum = clip23(psum + gene_term(g));
            gcnt++;
            if (gcnt < eg) return;
            gcnt = 0;
            fit = clip23(107259 * longint'(eg) - psum);
            psum = 0;
            if (ccnt == 0 || fit < best_fit) begin
                best_fit = fit;
                best_idx = cur_idx;
            end
            ccnt++;
            if (ccnt < et) return;
            ccnt = 0;
            pending.push_back('{idx: best_idx[7:0], fit: best_fit[FitW-1:0]});
        endfunction

        function void check_winner(logic [IdxW-1:0] idx, logic [FitW-1:0] fit);
            t_winner w;
            if (pending.size() == 0) begin
                $error("winner_index unexpected result: actual %0d", idx);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (w.idx !== idx) begin
                $error("winner_index expected %0d actual %0d", w.idx, idx);
                errors++;
            end
            if (w.fit !== fit) begin
                $error("winner_fitness expected %0d actual %0d", $signed(w.fit),
                    $signed(fit));
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    always #5 i_clk = ~i_clk;

    sts_gene_if   gene_ch();
    sts_winner_if win_ch();
    sts_cfg_if    cfg_ch();

    schwefel_tournament_select dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_gene(gene_ch.sink), .o_winner(win_ch.source), .i_cfg(cfg_ch.sink)
    );

    winner_board board = new();
    int  idle_cycles = 0;
    int  hold_off = 0;
    bit  stall_mode = 0;

    initial begin
        gene_ch.valid = 0;
        gene_ch.gene_value = '0;
        gene_ch.candidate_index = '0;
        cfg_ch.valid = 0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        win_ch.ready = 0;
    end

    // receiver: own stall pattern plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (win_ch.valid && win_ch.ready)
            board.check_winner(win_ch.winner_index, win_ch.winner_fitness);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            win_ch.ready <= 0;
        end else if (stall_mode) begin
            win_ch.ready <= ($urandom_range(0, 3) != 0);
        end else begin
            win_ch.ready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if ((gene_ch.valid && gene_ch.ready) || (win_ch.valid && win_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_gene(logic [GeneW-1:0] g, logic [IdxW-1:0] ci);
        gene_ch.valid <= 1;
        gene_ch.gene_value <= g;
        gene_ch.candidate_index <= ci;
        @(posedge i_clk);
        while (!gene_ch.ready) @(posedge i_clk);
        board.note_gene(g, ci);
    endtask

    task automatic gap();
        gene_ch.valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic drain();
        gene_ch.valid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
        gene_ch.valid <= 0;
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.write_reg(idx, d);
        cfg_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [GeneW-1:0] rand_gene();
        case ($urandom_range(0, 5))
            0: return 18'($urandom);
            1: return 18'h1ffff;
            2: return 18'h20000;
            default: return 18'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    task automatic burst_run(int count);
        int left, b;
        left = count;
        while (left > 0) begin
            b = $urandom_range(1, 12);
            if ($urandom_range(0, 4) == 0) b = 40;
            while (b > 0 && left > 0) begin
                send_gene(rand_gene(), 8'($urandom));
                b--; left--;
            end
            if ($urandom_range(0, 2) != 0) gap();
        end
    endtask

    initial begin
        logic [GeneW-1:0] edge_genes[8];
        edge_genes = '{18'h1ffff, 18'h20000, 18'h0, 18'h1, 18'h3ffff,
                       18'h0e5e9, 18'h31a17, 18'h10000};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, ties with tiny tournaments, unused indices, then out-of-range sizes
        write_cfg(CfgNumGenes, 5'd1);
        write_cfg(CfgTsize, 5'd8);
        for (int i = 0; i < 8; i++) send_gene(edge_genes[i], 8'(i * 37));
        write_cfg(CfgTsize, 5'd2);
        send_gene(18'h100, 8'd255);
        send_gene(18'h100, 8'd7);
        write_cfg(CfgNumGenes, 5'd2);
        send_gene(18'h1ffff, 8'd3);
        send_gene(18'h20000, 8'd200);
        send_gene(18'h0, 8'd4);
        send_gene(18'h0, 8'd4);
        write_cfg(2'd2, 5'd9);
        write_cfg(2'd3, 5'd1);
        send_gene(18'h400, 8'd10);
        drain();
        write_cfg(CfgNumGenes, 5'd0);
        write_cfg(CfgTsize, 5'd0);
        send_gene(18'h2000, 8'd1);
        send_gene(18'h3e000, 8'd2);
        write_cfg(CfgNumGenes, 5'd31);
        write_cfg(CfgTsize, 5'd15);
        drain();

        stall_mode = 1;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_cfg(CfgNumGenes, 5'd1);  write_cfg(CfgTsize, 5'd1); end
                1: begin write_cfg(CfgNumGenes, 5'd16); write_cfg(CfgTsize, 5'd1); end
                2: begin write_cfg(CfgNumGenes, 5'd2);  write_cfg(CfgTsize, 5'd8); end
                default: begin
                    write_cfg(CfgNumGenes, 5'($urandom_range(1, 5)));
                    write_cfg(CfgTsize, 5'($urandom_range(1, 4)));
                end
            endcase
            if (ph == 3) hold_off <= 3000;
            stall_mode = (ph % 2 == 0);
            burst_run(160);
            drain();
        end
        if (board.pending.size() == 0 && board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
